@@ src/jsu_pkg.sv @@
// Shared types and constants for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

  // Results one input byte can cause: four UTF-8 bytes and an error
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntWidth   = $clog2(MaxResults + 1);
  localparam int unsigned LenWidth   = 12;
  localparam int unsigned CapWidth   = 13;

  // Capacity after reset, stored as the kept-byte limit (capacity - 1)
  localparam logic [LenWidth-1:0] LimReset = 12'd255;
  localparam logic [CapWidth-1:0] CapMax   = 13'd4096;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOT_STR  = 3'd1,
    ERR_BAD_ESC  = 3'd2,
    ERR_BAD_HEX  = 3'd3,
    ERR_UNTERM   = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    MODE_WAIT = 4'b0001,
    MODE_BODY = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e               kind;
    logic [7:0]          data;
    logic [LenWidth-1:0] len;
    err_e                err;
    logic                last;
  } result_t;

  typedef result_t [MaxResults-1:0] result_list_t;

endpackage
`default_nettype wire

@@ src/jsu_decode.sv @@
// Decoder state and per-byte unescape / UTF-8 encode logic.
`timescale 1ns / 1ps
`default_nettype none
module jsu_decode (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           accept_i,
  input  wire  [7:0]                    byte_i,
  input  wire                           end_i,
  input  wire  [jsu_pkg::LenWidth-1:0]  lim_i,
  output jsu_pkg::result_list_t         res_o,
  output logic [jsu_pkg::CntWidth-1:0]  num_o
);
  import jsu_pkg::*;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBack  = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChU     = 8'h75;

  // nibble value, bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  mode_e       mode_q, mode_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [11:0] acc_q, acc_d;
  logic [9:0]  high_q, high_d;
  logic        pend_q, pend_d;
  logic [15:0] cnt_q, cnt_d;

  logic        raw_en;
  logic [7:0]  raw_byte;
  logic        cp_en;
  logic [20:0] cp;
  logic        tail_en;
  kind_e       tail_kind;
  err_e        tail_err;
  logic        done;
  logic        clear;
  logic [4:0]  nib;
  logic [15:0] cp16;
  logic [LenWidth-1:0] kept_len;

  logic [3:0][7:0] bytes;
  logic [2:0]      nb;
  logic [4:0]      keep;
  logic [CntWidth-1:0] m;
  logic [CntWidth-1:0] n;
  logic [16:0]     cnt_sum;

  assign nib      = hex_nib(byte_i);
  assign cp16     = {acc_q, nib[3:0]};
  assign kept_len = ({4'b0, lim_i} > cnt_q) ? cnt_q[LenWidth-1:0] : lim_i;

  // Per-mode decision for the incoming byte
  always_comb begin
    mode_d    = mode_q;
    hcnt_d    = hcnt_q;
    acc_d     = acc_q;
    high_d    = high_q;
    pend_d    = pend_q;
    raw_en    = 1'b0;
    raw_byte  = byte_i;
    cp_en     = 1'b0;
    cp        = '0;
    tail_en   = 1'b0;
    tail_kind = KIND_FAIL;
    tail_err  = ERR_NONE;
    done      = 1'b0;
    clear     = 1'b0;
    case (mode_q)
      MODE_WAIT: begin
        if (byte_i == ChQuote) begin
          clear = 1'b1;
        end else begin
          tail_en  = 1'b1;
          tail_err = ERR_NOT_STR;
          done     = 1'b1;
        end
      end
      MODE_BODY: begin
        if (byte_i == ChQuote) begin
          tail_en   = 1'b1;
          tail_kind = KIND_DONE;
          done      = 1'b1;
        end else if (byte_i == ChBack) begin
          mode_d = MODE_ESC;
        end else begin
          pend_d = 1'b0;
          raw_en = 1'b1;
        end
      end
      MODE_ESC: begin
        if (byte_i == ChU) begin
          mode_d = MODE_HEX;
          hcnt_d = '0;
          acc_d  = '0;
        end else begin
          pend_d = 1'b0;
          mode_d = MODE_BODY;
          if (byte_i == ChQuote || byte_i == ChBack || byte_i == ChSlash) begin
            raw_en = 1'b1;
          end else if (byte_i == 8'h62 || byte_i == 8'h66 || byte_i == 8'h6E ||
                       byte_i == 8'h72 || byte_i == 8'h74) begin
            raw_en   = 1'b1;
            raw_byte = ChSpace;
          end else begin
            tail_en  = 1'b1;
            tail_err = ERR_BAD_ESC;
            done     = 1'b1;
          end
        end
      end
      MODE_HEX: begin
        if (nib[4]) begin
          tail_en  = 1'b1;
          tail_err = ERR_BAD_HEX;
          done     = 1'b1;
        end else if (hcnt_q == 2'd3) begin
          hcnt_d = '0;
          acc_d  = '0;
          mode_d = MODE_BODY;
          pend_d = 1'b0;
          if (pend_q && cp16 >= 16'hDC00 && cp16 <= 16'hDFFF) begin
            // surrogate pair: 0x10000 + (high << 10) + low
            cp_en = 1'b1;
            cp    = {1'b0, high_q, cp16[9:0]} + 21'h10000;
          end else if (cp16 >= 16'hD800 && cp16 <= 16'hDBFF) begin
            pend_d = 1'b1;
            high_d = cp16[9:0];
          end else if (cp16 < 16'hDC00 || cp16 > 16'hDFFF) begin
            cp_en = 1'b1;
            cp    = {5'b0, cp16};
          end
        end else begin
          hcnt_d = hcnt_q + 2'd1;
          acc_d  = {acc_q[7:0], nib[3:0]};
        end
      end
      default: begin
        tail_en  = 1'b1;
        tail_err = ERR_NOT_STR;
        done     = 1'b1;
      end
    endcase
    // end of buffer on a byte that did not finish the string
    if (!done && end_i) begin
      tail_en   = 1'b1;
      tail_kind = KIND_FAIL;
      tail_err  = ERR_UNTERM;
      done      = 1'b1;
    end
  end

  // UTF-8 encoder / raw byte path
  always_comb begin
    bytes = '0;
    nb    = '0;
    if (raw_en) begin
      nb       = 3'd1;
      bytes[0] = raw_byte;
    end else if (cp_en) begin
      if (cp < 21'h80) begin
        nb       = 3'd1;
        bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        nb       = 3'd2;
        bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
        bytes[1] = 8'h80 | {2'b0, cp[5:0]};
      end else if (cp < 21'h10000) begin
        nb       = 3'd3;
        bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
        bytes[1] = 8'h80 | {2'b0, cp[11:6]};
        bytes[2] = 8'h80 | {2'b0, cp[5:0]};
      end else begin
        nb       = 3'd4;
        bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
        bytes[1] = 8'h80 | {2'b0, cp[17:12]};
        bytes[2] = 8'h80 | {2'b0, cp[11:6]};
        bytes[3] = 8'h80 | {2'b0, cp[5:0]};
      end
    end
  end

  // Saturating byte count and state clear
  always_comb begin
    cnt_sum = {1'b0, cnt_q} + {14'b0, nb};
    cnt_d   = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
    if (clear) begin
      cnt_d = '0;
    end
  end

  // Kept bytes form a prefix: byte k is kept while count + k < limit
  always_comb begin
    keep = '0;
    m    = '0;
    for (int k = 0; k < 4; k++) begin
      keep[k] = (3'(k) < nb) && (({1'b0, cnt_q} + 17'(k)) < {5'b0, lim_i});
      m       = m + CntWidth'(keep[k]);
    end
    n = m + CntWidth'(tail_en);
  end

  // Result list
  always_comb begin
    res_o = '0;
    for (int i = 0; i < MaxResults; i++) begin
      if (i < 4 && keep[i]) begin
        res_o[i].kind = KIND_DATA;
        res_o[i].data = bytes[i[1:0]];
      end else if (tail_en && CntWidth'(i) == m) begin
        res_o[i].kind = tail_kind;
        res_o[i].err  = (tail_kind == KIND_DONE) ? ERR_NONE : tail_err;
        res_o[i].len  = (tail_kind == KIND_DONE) ? kept_len : '0;
      end
      res_o[i].last = (CntWidth'(i) + CntWidth'(1)) == n;
    end
    num_o = n;
  end

  // Decoder state, updated on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_WAIT;
      hcnt_q <= '0;
      acc_q  <= '0;
      high_q <= '0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      if (done) begin
        mode_q <= MODE_WAIT;
        hcnt_q <= '0;
        acc_q  <= '0;
        high_q <= '0;
        pend_q <= 1'b0;
        cnt_q  <= '0;
      end else if (clear) begin
        mode_q <= MODE_BODY;
        hcnt_q <= '0;
        acc_q  <= '0;
        high_q <= '0;
        pend_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        mode_q <= mode_d;
        hcnt_q <= hcnt_d;
        acc_q  <= acc_d;
        high_q <= high_d;
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // a finished or failed string always returns to waiting for a quote
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && tail_en |=> mode_q == MODE_WAIT)
    else $error("decoder did not restart after a final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    num_o <= CntWidth'(MaxResults))
    else $error("decoder result count out of range");

endmodule
`default_nettype wire

@@ src/jsu_out_queue.sv @@
// Result register bank that hands out one result per transfer.
`timescale 1ns / 1ps
`default_nettype none
module jsu_out_queue (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           load_i,
  input  jsu_pkg::result_list_t         res_i,
  input  wire  [jsu_pkg::CntWidth-1:0]  num_i,
  output logic                          room_o,
  output logic                          valid_o,
  input  wire                           ready_i,
  output jsu_pkg::result_t              head_o
);
  import jsu_pkg::*;

  result_list_t        ent_q, ent_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                pop;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && ready_i;
  // a new list may load once the bank drains in this cycle
  assign room_o  = (cnt_q == '0) || (cnt_q == CntWidth'(1) && ready_i);
  assign head_o  = ent_q[0];

  // Load a fresh list or shift down on each transfer
  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = res_i;
      cnt_d = num_i;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntWidth'(MaxResults))
    else $error("result bank overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == '0) || (cnt_q == CntWidth'(1) && pop))
    else $error("result bank loaded while results still pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && cnt_q == CntWidth'(1) |-> head_o.last)
    else $error("final queued result lacks its last mark");

endmodule
`default_nettype wire

@@ src/json_string_unescape_utf8.sv @@
// Top level: JSON string unescaper emitting UTF-8 bytes on a stream.
// A result appears on the master side in the cycle after its input transfer.
// Throughput: one input byte per cycle while the receiver is ready and each byte yields at
// most one result. A byte yielding more (a \u escape end, or end-of-buffer error) holds
// input as the single-read result bank drains them, one per cycle while the receiver is ready.
// Reset: waits for an opening quote, byte count cleared, capacity 256.
`timescale 1ns / 1ps
`default_nettype none
module json_string_unescape_utf8 (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [12:0] cfg_wdata_i,    // out_capacity
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire         s_axis_tlast,   // buffer_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [19:8] text_length, [22:20] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);
  import jsu_pkg::*;

  logic [LenWidth-1:0] lim_q;
  logic                accept;
  logic                room;
  result_list_t        res_list;
  logic [CntWidth-1:0] res_num;
  result_t             head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Capacity kept as its byte limit, clamped to 1..4096 before the minus one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LimReset;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        lim_q <= '0;
      end else if (cfg_wdata_i > CapMax) begin
        lim_q <= '1;
      end else begin
        lim_q <= LenWidth'(cfg_wdata_i - 13'd1);
      end
    end
  end

  jsu_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .end_i    (s_axis_tlast),
    .lim_i    (lim_q),
    .res_o    (res_list),
    .num_o    (res_num)
  );

  jsu_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .res_i   (res_list),
    .num_i   (res_num),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  // Output packing
  assign m_axis_tdata = {1'b0, head.err, head.len, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the JSON string unescaper (UTF-8 output stream).
`timescale 1ns / 1ps
module tb;
  import jsu_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LatencySlack = 4;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_U      = 8'h75;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Decoder state mirrored by the predictor
  mode_e       mode_q;
  logic [1:0]  hex_cnt_q;
  logic [15:0] hex_acc_q;
  logic [9:0]  hi_bits_q;
  logic        pair_pend_q;
  logic [15:0] byte_count_q;
  logic [12:0] capacity_q = 13'd256;

  result_t     step_q[$];
  result_t     due_q[$];
  logic [7:0]  str_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;

  json_string_unescape_utf8 dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d results still due", cycle_cnt, due_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= snk_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [11:0] kept_limit();
    logic [12:0] cap;
    cap = capacity_q;
    if (cap < 13'd1) cap = 13'd1;
    if (cap > CapMax) cap = CapMax;
    return 12'(cap - 13'd1);
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd16;
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == "b" || c == "f" ||
           c == "n" || c == "r" || c == "t";
  endfunction

  task automatic clear_decoder();
    mode_q       = MODE_WAIT;
    hex_cnt_q    = '0;
    hex_acc_q    = '0;
    hi_bits_q    = '0;
    pair_pend_q  = 1'b0;
    byte_count_q = '0;
  endtask

  task automatic add_result(kind_e k, logic [7:0] d, logic [11:0] l, err_e e);
    result_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    r.err  = e;
    r.last = 1'b0;
    step_q.push_back(r);
  endtask

  task automatic fail_string(err_e e);
    add_result(KIND_FAIL, 8'd0, 12'd0, e);
    clear_decoder();
  endtask

  // Every byte counts; only those below the kept limit go out
  task automatic emit_text_byte(logic [7:0] b);
    if (byte_count_q < {4'd0, kept_limit()}) add_result(KIND_DATA, b, 12'd0, ERR_NONE);
    if (byte_count_q != 16'hFFFF) byte_count_q++;
  endtask

  task automatic emit_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_text_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_text_byte(8'hC0 | 8'(cp >> 6));
      emit_text_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit_text_byte(8'hE0 | 8'(cp >> 12));
      emit_text_byte({2'b10, cp[11:6]});
      emit_text_byte({2'b10, cp[5:0]});
    end else begin
      emit_text_byte({5'b11110, cp[20:18]});
      emit_text_byte({2'b10, cp[17:12]});
      emit_text_byte({2'b10, cp[11:6]});
      emit_text_byte({2'b10, cp[5:0]});
    end
  endtask

  // A completed \u code unit: pair it, hold it, drop it or emit it
  task automatic close_code_unit(logic [15:0] cu);
    bit paired;
    paired = 1'b0;
    if (pair_pend_q) begin
      pair_pend_q = 1'b0;
      if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
        emit_code_point(21'h10000 + (21'(hi_bits_q) << 10) + 21'(cu - 16'hDC00));
        paired = 1'b1;
      end
    end
    if (!paired) begin
      if (cu >= 16'hD800 && cu <= 16'hDBFF) begin
        pair_pend_q = 1'b1;
        hi_bits_q   = 10'(cu - 16'hD800);
      end else if (cu < 16'hDC00 || cu > 16'hDFFF) begin
        emit_code_point(21'(cu));
      end
    end
  endtask

  // Work out the results of one accepted byte and queue them
  task automatic predict_byte(logic [7:0] c, logic at_end);
    bit          done;
    logic [4:0]  nib;
    logic [15:0] cu;
    logic [11:0] lim;
    done = 1'b0;
    step_q.delete();
    case (mode_q)
      MODE_WAIT: begin
        if (c == CH_QUOTE) begin
          clear_decoder();
          mode_q = MODE_BODY;
        end else begin
          fail_string(ERR_NOT_STR);
          done = 1'b1;
        end
      end
      MODE_BODY: begin
        if (c == CH_QUOTE) begin
          lim = kept_limit();
          add_result(KIND_DONE, 8'd0,
                     (byte_count_q < {4'd0, lim}) ? byte_count_q[11:0] : lim, ERR_NONE);
          clear_decoder();
          done = 1'b1;
        end else if (c == CH_BSLASH) begin
          mode_q = MODE_ESC;
        end else begin
          pair_pend_q = 1'b0;
          emit_text_byte(c);
        end
      end
      MODE_ESC: begin
        if (c == CH_U) begin
          mode_q    = MODE_HEX;
          hex_cnt_q = '0;
          hex_acc_q = '0;
        end else begin
          pair_pend_q = 1'b0;
          mode_q      = MODE_BODY;
          if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
            emit_text_byte(c);
          end else if (is_escape_char(c)) begin
            emit_text_byte(CH_SPACE);
          end else begin
            fail_string(ERR_BAD_ESC);
            done = 1'b1;
          end
        end
      end
      MODE_HEX: begin
        nib = hex_value(c);
        if (nib[4]) begin
          fail_string(ERR_BAD_HEX);
          done = 1'b1;
        end else begin
          hex_acc_q = {hex_acc_q[11:0], nib[3:0]};
          hex_cnt_q = hex_cnt_q + 2'd1;
          if (hex_cnt_q == 2'd0) begin
            cu        = hex_acc_q;
            hex_acc_q = '0;
            mode_q    = MODE_BODY;
            close_code_unit(cu);
          end
        end
      end
      default: begin
        clear_decoder();
        fail_string(ERR_NOT_STR);
        done = 1'b1;
      end
    endcase
    if (!done && at_end) fail_string(ERR_UNTERM);
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) due_q.push_back(step_q[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH cycle %0d result %0d: %s got 0x%0h expected 0x%0h",
               cycle_cnt, results_seen, what, got, want);
  endtask

  // tdata: [7:0] data_byte, [19:8] text_length, [22:20] error_code; tuser: kind
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (due_q.size() == 0) begin
        report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
      end else begin
        want = due_q.pop_front();
        if (m_axis_tuser != want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[7:0] != want.data)
          report_mismatch("data_byte", m_axis_tdata[7:0], want.data);
        if (m_axis_tdata[19:8] != want.len)
          report_mismatch("text_length", m_axis_tdata[19:8], want.len);
        if (m_axis_tdata[22:20] != want.err)
          report_mismatch("error_code", m_axis_tdata[22:20], want.err);
        if (m_axis_tdata[23] != 1'b0) report_mismatch("tdata padding", m_axis_tdata[23], 0);
        if (m_axis_tlast != want.last) report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_byte(logic [7:0] b, logic at_end);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = at_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_byte(b, at_end);
    bytes_sent++;
  endtask

  task automatic send_string(bit end_on_last);
    for (int i = 0; i < str_q.size(); i++)
      send_byte(str_q[i], end_on_last && (i == str_q.size() - 1));
  endtask

  // Hold off the sender until every due result has been seen
  task automatic drain_outputs();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (due_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [12:0] v);
    drain_outputs();
    repeat (LatencySlack) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we     = 1'b0;
    capacity_q = v;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib - 4'd10);
  endfunction

  function automatic logic [7:0] random_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  task automatic add_hex_escape(logic [15:0] cu);
    str_q.push_back(CH_BSLASH);
    str_q.push_back(CH_U);
    str_q.push_back(hex_char(cu[15:12]));
    str_q.push_back(hex_char(cu[11:8]));
    str_q.push_back(hex_char(cu[7:4]));
    str_q.push_back(hex_char(cu[3:0]));
  endtask

  // One piece of string content: raw byte, short escape or \u escape
  task automatic add_token();
    logic [15:0] cu;
    case ($urandom_range(9))
      0, 1, 2, 3: str_q.push_back(random_text_byte());
      4: begin
        str_q.push_back(CH_BSLASH);
        case ($urandom_range(7))
          0: str_q.push_back(CH_QUOTE);
          1: str_q.push_back(CH_BSLASH);
          2: str_q.push_back(CH_SLASH);
          3: str_q.push_back("b");
          4: str_q.push_back("f");
          5: str_q.push_back("n");
          6: str_q.push_back("r");
          default: str_q.push_back("t");
        endcase
      end
      5: begin
        case ($urandom_range(3))
          0: cu = 16'($urandom_range(16'h7F));
          1: cu = 16'($urandom_range(16'h7FF));
          2: cu = 16'($urandom_range(16'hFFFF));
          default: begin
            // encoding-length boundaries
            case ($urandom_range(5))
              0: cu = 16'h0000;
              1: cu = 16'h007F;
              2: cu = 16'h0080;
              3: cu = 16'h07FF;
              4: cu = 16'h0800;
              default: cu = 16'hFFFF;
            endcase
          end
        endcase
        add_hex_escape(cu);
      end
      6: begin
        add_hex_escape(16'(16'hD800 + $urandom_range(10'h3FF)));
        add_hex_escape(16'(16'hDC00 + $urandom_range(10'h3FF)));
      end
      7: add_hex_escape(16'(16'hD800 + $urandom_range(10'h3FF)));
      8: add_hex_escape(16'(16'hDC00 + $urandom_range(10'h3FF)));
      default: add_hex_escape(16'($urandom_range(16'hFFFF)));
    endcase
  endtask

  // Mostly well-formed strings; the rest are cut short or broken
  task automatic send_random_string(int unsigned max_tok);
    int unsigned pick;
    int unsigned cut;
    logic [7:0]  b;
    logic [4:0]  hv;
    bit          end_last;
    pick     = $urandom_range(99);
    end_last = 1'b0;
    str_q.delete();
    str_q.push_back(CH_QUOTE);
    repeat ($urandom_range(max_tok)) add_token();
    str_q.push_back(CH_QUOTE);
    if (pick < 8) begin
      end_last = 1'b1;
    end else if (pick >= 75) begin
      cut   = $urandom_range(str_q.size() - 2);
      str_q = str_q[0:cut];
      case (pick % 4)
        0: begin
          do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
          str_q.delete();
          str_q.push_back(b);
        end
        1: begin
          do b = 8'($urandom_range(255)); while (is_escape_char(b) || b == CH_U);
          str_q.push_back(CH_BSLASH);
          str_q.push_back(b);
        end
        2: begin
          str_q.push_back(CH_BSLASH);
          str_q.push_back(CH_U);
          repeat ($urandom_range(3)) str_q.push_back(hex_char(4'($urandom_range(15))));
          do begin
            b  = 8'($urandom_range(255));
            hv = hex_value(b);
          end while (!hv[4]);
          str_q.push_back(b);
        end
        default: end_last = 1'b1;
      endcase
    end
    send_string(end_last);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset capacity; field extremes, each escape kind and each error
  task automatic test_directed_cases();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    // missing opening quote
    str_q = '{8'hFF};
    send_string(1'b0);
    // raw extremes, short escape, lone high then plain byte, lone low; end on quote
    str_q = '{CH_QUOTE, 8'h00, 8'hFF};
    push_text("\\n\\uDBFFA\\uDC00\"");
    send_string(1'b1);
    // bad escape
    str_q.delete();
    push_text("\"\\q");
    send_string(1'b0);
    // bad hex digit wins over the end flag
    str_q.delete();
    push_text("\"\\ug");
    send_string(1'b1);
    // truncated \u escape
    str_q.delete();
    push_text("\"\\u0");
    send_string(1'b1);
    // highest code point, then end of buffer: four bytes plus the error
    str_q.delete();
    push_text("\"\\uDBFF\\uDFFF");
    send_string(1'b1);
  endtask

  task automatic test_capacity_extremes();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    write_capacity(13'd1);
    repeat (2) send_random_string(6);
    write_capacity(13'd0);
    repeat (2) send_random_string(6);
    write_capacity(13'd2);
    repeat (3) send_random_string(6);
    write_capacity(13'd4096);
    send_random_string(6);
    write_capacity(13'h1FFF);
    send_random_string(6);
  endtask

  task automatic test_random_stream(int unsigned src_pct, int unsigned snk_pct,
                                    logic [12:0] cap, int unsigned n_bytes);
    int unsigned start;
    bit          paused;
    write_capacity(cap);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < n_bytes) begin
      send_random_string(8);
      if (!paused && bytes_sent - start >= n_bytes / 2) begin
        drain_outputs();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    clear_decoder();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_capacity_extremes();
    test_random_stream(0, 0, 13'd256, 45);
    test_random_stream(77, 0, 13'd5, 45);
    test_random_stream(0, 77, 13'(3 + $urandom_range(40)), 45);
    test_random_stream(11, 11, 13'd8, 45);
    drain_outputs();
    repeat (10) @(posedge clk);
    $display("Run covered %0d input bytes and %0d results over capacities 0 to 8191,",
             bytes_sent, results_seen);
    $display("with free-running, sender-idle, receiver-stall and mixed traffic; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
